[hw/rtl/integer_to_radix_digits_defines.svh]
// Assertion macros shared by the integer_to_radix_digits RTL.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/itrd_pkg.sv]
// Shared constants, types and helper functions for the radix digit converter.
`default_nettype none
package itrd_pkg;

  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int COUNT_W    = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_DATA_W   = ((CHAR_W + 7) / 8) * 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

  // Register index, taken from paddr above the byte offset.
  localparam logic [PADDR_W-3:0] REG_RADIX = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_FETCH,
    ST_SEND
  } itrd_state_t;

  // Result of one divider pass.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } itrd_div_result_t;

  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) c = CHAR_ZERO + CHAR_W'(d);
    else c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/itrd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/itrd_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module itrd_divider
  import itrd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]    divisor,
  output itrd_div_result_t           result
);

  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W-1:0]    rem;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem, quo[VALUE_BITS-1]};
    diff  = trial - {{(DIGIT_W + 1 - RADIX_W){1'b0}}, divisor};
    fits  = trial >= {{(DIGIT_W + 1 - RADIX_W){1'b0}}, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(VALUE_BITS - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], fits};
      rem <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule
`default_nettype wire

[hw/rtl/integer_to_radix_digits.sv]
// Top level of the integer to ASCII radix digit converter.
// Each digit takes a start state, VALUE_BITS = 31 divider steps and the divider's done pulse.
// An item of n digits runs n divider passes, then a FETCH and a SEND state per output beat.
// The bit-serial divider sets the rate; the block takes a new value only once the last beat is gone.
// Reset is synchronous and active high: radix returns to 10, the sequencer goes idle.
// The digit store is not cleared; every entry read was written during the same conversion.
`default_nettype none
`include "integer_to_radix_digits_defines.svh"
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Input stream. s_tdata: value in [30:0], zero fill above.
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // Output stream. m_tdata: digit_char in [6:0], zero fill above. m_tlast: last_digit.
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata,
  output logic                     m_tlast,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  itrd_state_t state, state_next;

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] working_quotient;
  logic [COUNT_W-1:0]    digit_count;
  logic [IDX_W-1:0]      idx;

  logic                  div_start;
  itrd_div_result_t      div_res;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    ram_rdata;
  logic                  in_beat;
  logic                  out_beat;
  logic                  cfg_write;
  logic                  has_room;

  assign in_beat   = s_tvalid && s_tready;
  assign out_beat  = m_tvalid && m_tready;
  assign has_room  = digit_count < COUNT_W'(VALUE_BITS);

  // The configuration register sits at byte address 0; the low two address
  // bits are the byte offset and are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_RADIX)) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_RADIX) begin
      prdata = {{(PDATA_W - RADIX_W){1'b0}}, radix};
    end
  end

  // The shared divider produces one remainder digit per pass. The radix is
  // saturated into the range 2 to 36 before it reaches the divisor input.
  itrd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (working_quotient),
    .divisor  (effective_radix(radix)),
    .result   (div_res)
  );

  // Remainders are stored least significant first and read back in reverse.
  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[IDX_W-1:0]),
    .wdata (div_res.remainder),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Next-state logic. A conversion loops through START and DIVIDE until the
  // quotient reaches zero, so a zero value still yields one digit.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_START;
      end
      ST_START: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_res.done) begin
          state_next = (div_res.quotient == '0) ? ST_FETCH : ST_START;
        end
      end
      ST_FETCH: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_beat) state_next = (idx == '0) ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    m_tvalid  = 1'b0;
    ram_we    = 1'b0;
    case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_DIVIDE: ram_we    = div_res.done && has_room;
      ST_SEND:   m_tvalid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      idx         <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_beat) digit_count <= '0;
        end
        ST_DIVIDE: begin
          if (div_res.done) begin
            if (has_room) digit_count <= digit_count + 1'b1;
            // The digit just written is the most significant one.
            if (div_res.quotient == '0) idx <= digit_count[IDX_W-1:0];
          end
        end
        ST_SEND: begin
          if (out_beat && (idx != '0)) idx <= idx - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      working_quotient <= '0;
    end else if (in_beat) begin
      working_quotient <= s_tdata[VALUE_BITS-1:0];
    end else if ((state == ST_DIVIDE) && div_res.done) begin
      working_quotient <= div_res.quotient;
    end
  end

  // The store read data is registered and stays put while a beat stalls,
  // because idx only moves after the beat is taken.
  assign m_tdata = {{(M_DATA_W - CHAR_W){1'b0}}, digit_to_ascii(ram_rdata)};
  assign m_tlast = (idx == '0);

  `ITRD_ASSERT_NOW(a_one_side_busy, m_tvalid, !s_tready, "input taken while a beat is pending")
  `ITRD_ASSERT_NOW(a_done_in_divide, div_res.done, state == ST_DIVIDE, "divider done out of place")
  `ITRD_ASSERT_NOW(a_count_bound, 1'b1, digit_count <= COUNT_W'(VALUE_BITS), "digit count overflow")
  `ITRD_ASSERT_NEXT(a_idx_step, out_beat && (idx != '0),
                    (state == ST_FETCH) && (idx == $past(idx) - 1'b1), "bad digit index step")

endmodule
`default_nettype wire

[bench/integer_to_radix_digits_tb.sv]
// Self-checking testbench for the integer to ASCII radix digit converter.
module integer_to_radix_digits_tb;
  import itrd_pkg::*;

  // The timeout sits far above the slowest correct run. That run has every value in
  // radix 2: 31 digits, each a full divider pass, plus receiver stalls on every beat.
  localparam int CYCLE_LIMIT      = 2_000_000;
  // After the last digit, wait out more than one full conversion to catch stray beats.
  localparam int DRAIN_CYCLES     = 1100;
  // The long receiver hold-off outlasts a whole conversion, so the converter finishes
  // its division, stalls on the first beat and keeps s_tready low meanwhile.
  localparam int HOLD_CYCLES      = 2000;
  localparam int BLOCKS_PER_PHASE = 7;
  localparam int VALUES_PER_BLOCK = 10;
  localparam int DIRECTED_ROWS    = 20;

  localparam logic [PADDR_W-1:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
  // Byte address 4 decodes to register index 1, which does not exist.
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

  // One expected character beat.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  // One directed row. An optional register write comes first, then one value.
  // When want is empty, the digits come from the software converter below.
  typedef struct {
    bit                    wr;
    logic [PADDR_W-1:0]    addr;
    logic [PDATA_W-1:0]    wdata;
    logic [VALUE_BITS-1:0] value;
    string                 want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // value [30:0], zero fill [31]
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // digit_char [6:0], zero fill [7]
  logic                m_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // This is the testbench copy of the radix register: six raw bits, as written.
  logic [RADIX_W-1:0] radix_reg;
  char_beat_t         chars_due[$];
  int                 mismatches;
  int                 cycles;
  int                 send_gap;    // percent of items preceded by sender idle cycles
  int                 recv_gap;    // percent of cycles with m_tready low
  int                 hold_reqs;   // bumped by the stimulus to ask for a long hold-off
  int                 hold_seen;
  int                 hold_left;
  dir_row_t           dir_rows[DIRECTED_ROWS];
  logic [RADIX_W-1:0] radix_edges[6];

  integer_to_radix_digits i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This is the software converter. The radix saturates to 2..36. The function divides
  // the value repeatedly and keeps the remainders. It then queues the characters with
  // the most significant first, so the least significant one carries the last flag.
  // A zero value still makes one digit.
  function automatic void convert_to_chars(input logic [VALUE_BITS-1:0] v);
    logic [RADIX_W-1:0]    base;
    logic [DIGIT_W-1:0]    rems[VALUE_BITS];
    logic [VALUE_BITS-1:0] quot;
    logic [CHAR_W-1:0]     ch;
    int                    n;
    base = radix_reg;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    quot = v;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(quot % base);
      n++;
      quot = quot / base;
    end while (quot != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < DEC_DIGITS) ch = CHAR_ZERO + CHAR_W'(rems[k]);
      else ch = CHAR_A + CHAR_W'(rems[k] - DEC_DIGITS);
      chars_due.push_back('{ch: ch, last: (k == 0)});
    end
  endfunction

  // Values come in random lengths, so that short and long digit runs both occur often.
  // Zero and the all-ones maximum also appear regularly.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned           mode;
    int unsigned           len;
    logic [VALUE_BITS-1:0] v;
    mode = $urandom_range(7);
    len  = $urandom_range(VALUE_BITS, 1);
    v    = VALUE_BITS'($urandom()) & ({VALUE_BITS{1'b1}} >> (VALUE_BITS - len));
    if (mode == 0) v = '0;
    else if (mode == 1) v = '1;
    return v;
  endfunction

  // This task offers one value and returns at the edge that accepts it, with s_tvalid
  // still high. The next call can keep the beat stream going without a bubble. The
  // expected characters are queued at acceptance, under the radix in force then.
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input string want);
    if ($urandom_range(99) < send_gap) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(v);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (want.len() == 0) begin
      convert_to_chars(v);
    end else begin
      for (int i = 0; i < want.len(); i++)
        chars_due.push_back('{ch: CHAR_W'(want[i]), last: (i == want.len() - 1)});
    end
  endtask

  // This task stops offering values and waits until every queued character has left.
  // After that, the converter is idle and a register write is safe.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
  endtask

  // This task does an APB read of the radix register and checks it against the copy.
  // It also ends the transfer. A preceding write runs straight into its setup phase.
  task automatic check_radix_read();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_RADIX;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(radix_reg)) begin
      $display("%0t: radix readback expected %h actual %h", $time, PDATA_W'(radix_reg),
               prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // This task does an APB write. A write to an index other than the radix register
  // changes nothing. A readback always follows.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[PADDR_W-1:2] == REG_RADIX) radix_reg = data[RADIX_W-1:0];
    check_radix_read();
  endtask

  // This is the receiver. Normally it stalls at random. When the stimulus asks for a
  // hold-off, it keeps m_tready low for a long count of its own instead.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap);
    end
  end

  // Every accepted character beat is checked against the oldest expectation. The check
  // covers the character, the zero fill above it, and the last flag.
  always @(posedge clk) begin : check_beats
    char_beat_t exp_beat;
    if (!rst && m_tvalid && m_tready) begin
      if (chars_due.size() == 0) begin
        $display("%0t: digit beat with nothing expected, expected none actual %h/%b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        exp_beat = chars_due.pop_front();
        if (m_tdata !== M_DATA_W'(exp_beat.ch)) begin
          $display("%0t: digit_char expected %h actual %h", $time, M_DATA_W'(exp_beat.ch),
                   m_tdata);
          mismatches++;
        end
        if (m_tlast !== exp_beat.last) begin
          $display("%0t: last_digit expected %b actual %b", $time, exp_beat.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [PDATA_W-1:0] wdata;
    logic [PADDR_W-1:0] waddr;

    // Rows with a typed string can be read off at a glance. They cover zero, the
    // 31-bit maximum, radix 2 and 36, and saturation from 0, 1, 37 and 63. They also
    // cover upper write bits that get dropped and a write to a missing register.
    dir_rows = '{
      '{0, ADDR_RADIX,  32'd0,          31'd0,          "0"},
      '{0, ADDR_RADIX,  32'd0,          31'h7FFF_FFFF,  "2147483647"},
      '{0, ADDR_RADIX,  32'd0,          31'd9,          "9"},
      '{0, ADDR_RADIX,  32'd0,          31'd10,         "10"},
      '{1, ADDR_RADIX,  32'd2,          31'h7FFF_FFFF,  "1111111111111111111111111111111"},
      '{0, ADDR_RADIX,  32'd0,          31'd1,          "1"},
      '{0, ADDR_RADIX,  32'd0,          31'h4000_0000,  ""},
      '{1, ADDR_RADIX,  32'd0,          31'd5,          "101"},
      '{1, ADDR_RADIX,  32'd1,          31'd6,          "110"},
      '{1, ADDR_RADIX,  32'd36,         31'd35,         "Z"},
      '{0, ADDR_RADIX,  32'd0,          31'd36,         "10"},
      '{0, ADDR_RADIX,  32'd0,          31'h7FFF_FFFF,  ""},
      '{1, ADDR_RADIX,  32'd37,         31'd35,         "Z"},
      '{1, ADDR_RADIX,  32'd63,         31'd71,         "1Z"},
      '{1, ADDR_RADIX,  32'hFFFF_FFD0,  31'd255,        "FF"},
      '{1, ADDR_UNUSED, 32'd2,          31'h7FFF_FFFF,  "7FFFFFFF"},
      '{1, ADDR_RADIX,  32'd11,         31'd120,        "AA"},
      '{0, ADDR_RADIX,  32'd0,          31'd10,         "A"},
      '{1, ADDR_RADIX,  32'd3,          31'h5555_5555,  ""},
      '{1, ADDR_RADIX,  32'd10,         31'd1234567,    "1234567"}
    };
    radix_edges = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    radix_reg  = RADIX_RESET;
    mismatches = 0;
    cycles     = 0;
    hold_reqs  = 0;
    hold_seen  = 0;
    hold_left  = 0;
    send_gap   = 6;
    recv_gap   = 71;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The radix must read back as its reset value before anything is written.
    check_radix_read();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        wait_idle();
        write_reg(dir_rows[i].addr, dir_rows[i].wdata);
      end
      send_value(dir_rows[i].value, dir_rows[i].want);
    end

    // The random part runs in three phases. First the sender idles lightly and the
    // receiver heavily. Then the two swap. Last, both run at full rate. Each block of
    // values starts from an idle converter after a register write, mostly of a fresh radix, often an extreme one.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap = 6;
          recv_gap = 71;
        end
        1: begin
          send_gap = 71;
          recv_gap = 6;
        end
        default: begin
          send_gap = 0;
          recv_gap = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        wait_idle();
        if ($urandom_range(2) == 0) wdata = PDATA_W'(radix_edges[$urandom_range(5)]);
        else wdata = PDATA_W'($urandom_range(36, 2));
        wdata = wdata | ($urandom() & ~PDATA_W'({RADIX_W{1'b1}}));
        waddr = ($urandom_range(7) == 0) ? ADDR_UNUSED : ADDR_RADIX;
        write_reg(waddr, wdata);
        // At the start of the full-rate phase, the receiver stops for a long stretch
        // while the sender keeps offering values.
        if (phase == 2 && blk == 0) hold_reqs++;
        for (int n = 0; n < VALUES_PER_BLOCK; n++) send_value(pick_value(), "");
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
